>>> sv/lrups_pkg.sv
// ----------------------------------------------------------------------------
// lrups_pkg
// Shared widths, reset values and the command word for the lru stack core.
// ----------------------------------------------------------------------------
package lrups_pkg;

  localparam int NUM_FRAMES_DEFAULT = 16;

  localparam int PAGE_W  = 16;
  localparam int CFG_W   = 5;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 16;

  localparam logic [CFG_W-1:0]   FRAMES_RESET = CFG_W'(3);
  localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};
  localparam logic [POS_W-1:0]   POS_MAX      = {POS_W{1'b1}};

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the word and register the compare result
    logic update;   // shift the stack and load the result registers
  } cmd_t;

endpackage

>>> sv/lrups_ctrl.sv
// ----------------------------------------------------------------------------
// lrups_ctrl
// Two-state sequencer: take a word, then apply it to the stack once the
// result register is free.
// ----------------------------------------------------------------------------
module lrups_ctrl
  import lrups_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_UPDATE = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic out_free;

  assign in_ready    = (state == ST_IDLE);
  assign out_free    = !out_valid || out_ready;
  assign cmd.capture = in_valid && in_ready;
  assign cmd.update  = (state == ST_UPDATE) && out_free;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      ST_IDLE: begin
        if (cmd.capture) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_next     = ST_IDLE;
          out_valid_next = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> sv/lrups_datapath.sv
// ----------------------------------------------------------------------------
// lrups_datapath
// Recency stack of page numbers with valid bits, parallel tag compare,
// first-match select, shift network, fault counter and result registers.
// ----------------------------------------------------------------------------
module lrups_datapath
  import lrups_pkg::*;
#(
  parameter int NUM_FRAMES = NUM_FRAMES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic               cfg_write_en,
  input  logic [CFG_W-1:0]   cfg_write_data,
  input  logic [PAGE_W-1:0]  page_number,
  output logic               hit,
  output logic [POS_W-1:0]   hit_position,
  output logic               evicted_valid,
  output logic [PAGE_W-1:0]  evicted_page,
  output logic [COUNT_W-1:0] fault_count
);

  localparam int FW = $clog2(NUM_FRAMES + 1);
  localparam int EW = (FW > CFG_W) ? FW : CFG_W;

  logic [CFG_W-1:0]      frames_in_use;
  logic [PAGE_W-1:0]     page_slot [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] slot_valid;
  logic [PAGE_W-1:0]     page_q;
  logic [NUM_FRAMES-1:0] match_q;
  logic [COUNT_W-1:0]    fault_counter;

  logic [EW-1:0]         frames_ext;
  logic [EW-1:0]         frames_eff;
  logic [NUM_FRAMES-1:0] in_range;
  logic [NUM_FRAMES-1:0] last_slot;
  logic [NUM_FRAMES-1:0] match_now;
  logic [NUM_FRAMES-1:0] first_hit;
  logic [NUM_FRAMES-1:0] shift_en;
  logic                  found;
  logic [POS_W-1:0]      pos;
  logic                  ev_valid;
  logic [PAGE_W-1:0]     ev_page;

  // zero acts as one frame, anything past the stack depth as the full stack
  assign frames_ext = EW'(frames_in_use);
  always_comb begin
    frames_eff = frames_ext;
    if (frames_ext == '0) begin
      frames_eff = EW'(1);
    end else if (frames_ext > EW'(NUM_FRAMES)) begin
      frames_eff = EW'(NUM_FRAMES);
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_FRAMES; i++) begin
      in_range[i]  = EW'(i) < frames_eff;
      last_slot[i] = EW'(i + 1) == frames_eff;
      match_now[i] = in_range[i] && slot_valid[i] && (page_slot[i] == page_number);
    end
  end

  // isolate the lowest set match bit
  assign found     = |match_q;
  assign first_hit = match_q & (~match_q + NUM_FRAMES'(1));
  // hit: slots up to the hit shift; miss: every slot in use shifts
  assign shift_en  = found ? (first_hit | (first_hit - NUM_FRAMES'(1))) : in_range;

  always_comb begin
    pos      = '0;
    ev_valid = 1'b0;
    ev_page  = '0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (first_hit[i]) begin
        pos = pos | ((i > 15) ? POS_MAX : POS_W'(i));
      end
      if (!found && last_slot[i] && slot_valid[i]) begin
        ev_valid = 1'b1;
        ev_page  = ev_page | page_slot[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_RESET;
    end else if (cfg_write_en) begin
      frames_in_use <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_q  <= page_number;
      match_q <= match_now;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      page_slot[0] <= page_q;
      for (int i = 1; i < NUM_FRAMES; i++) begin
        if (shift_en[i]) begin
          page_slot[i] <= page_slot[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid    <= '0;
      fault_counter <= '0;
    end else if (cmd.update) begin
      slot_valid[0] <= 1'b1;
      for (int i = 1; i < NUM_FRAMES; i++) begin
        if (shift_en[i]) begin
          slot_valid[i] <= slot_valid[i-1];
        end
      end
      if (!found && fault_counter != COUNT_MAX) begin
        fault_counter <= fault_counter + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hit           <= found;
      hit_position  <= pos;
      evicted_valid <= ev_valid;
      evicted_page  <= ev_page;
    end
  end

  // counter only moves together with the result registers
  assign fault_count = fault_counter;

endmodule

>>> sv/lru_page_replacement_stack_core.sv
// ----------------------------------------------------------------------------
// lru_page_replacement_stack_core
// LRU stack of resident pages with hit/miss, eviction and fault count output.
// ----------------------------------------------------------------------------
// The accept cycle compares the page against all frames in parallel and
// registers the match vector; the update cycle, once the result register is
// free, picks the most recent match, shifts the stack and loads the result
// register. No new word is accepted before that update; a held result only
// stalls the update cycle. frames_in_use is written through cfg_write_en and
// cfg_write_data; the user must write it only while no word is in flight, and
// the block does not enforce this. 0 means one frame, values past NUM_FRAMES
// mean NUM_FRAMES. The stack starts empty after reset, with no clearing pass.
module lru_page_replacement_stack_core
  import lrups_pkg::*;
#(
  parameter int NUM_FRAMES = NUM_FRAMES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PAGE_W-1:0]  page_number,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic [POS_W-1:0]   hit_position,
  output logic               evicted_valid,
  output logic [PAGE_W-1:0]  evicted_page,
  output logic [COUNT_W-1:0] fault_count,
  input  logic               cfg_write_en,
  input  logic [CFG_W-1:0]   cfg_write_data
);

  cmd_t cmd;

  lrups_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lrups_datapath #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .page_number    (page_number),
    .hit            (hit),
    .hit_position   (hit_position),
    .evicted_valid  (evicted_valid),
    .evicted_page   (evicted_page),
    .fault_count    (fault_count)
  );

  // one word in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted while another is in flight");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted_valid))
    else $error("eviction reported on a hit");

  a_miss_pos_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_position == '0)
    else $error("nonzero hit position on a miss");

  a_evict_page_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted_valid |-> evicted_page == '0)
    else $error("evicted page without eviction");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> fault_count >= $past(fault_count))
    else $error("fault count went down");

endmodule
